// ===== hw/rtl/ptd_pkg.sv =====
// Shared types and constants for the trace packet decoder.
// Holds the item structs, kind codes, header bytes and controller links.
// Depends on nothing.
`default_nettype none
package ptd_pkg;

  localparam int WinBytes = 16;
  localparam int FillW = 5;
  localparam int CntW = 32;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] byte_offset;
    logic [63:0] payload;
    logic [31:0] aux_value;
    logic [5:0]  tnt_count;
    logic        error_flag;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic sync_step;
    logic decode;
    logic summary;
  } ptd_cmd_t;

  typedef struct packed {
    logic in_sync;
    logic fill_full;
    logic fill_nz;
    logic draining;
  } ptd_status_t;

  localparam logic [4:0] K_PAD       = 5'd0;
  localparam logic [4:0] K_TNT8      = 5'd1;
  localparam logic [4:0] K_TNT64     = 5'd2;
  localparam logic [4:0] K_PIP       = 5'd3;
  localparam logic [4:0] K_CBR       = 5'd4;
  localparam logic [4:0] K_STOP      = 5'd5;
  localparam logic [4:0] K_OVF       = 5'd6;
  localparam logic [4:0] K_PSB       = 5'd7;
  localparam logic [4:0] K_PSBEND    = 5'd8;
  localparam logic [4:0] K_MNT       = 5'd9;
  localparam logic [4:0] K_TMA       = 5'd10;
  localparam logic [4:0] K_VMCS      = 5'd11;
  localparam logic [4:0] K_TIP       = 5'd12;
  localparam logic [4:0] K_TIP_PGE   = 5'd13;
  localparam logic [4:0] K_TIP_PGD   = 5'd14;
  localparam logic [4:0] K_FUP       = 5'd15;
  localparam logic [4:0] K_MODE_TSX  = 5'd16;
  localparam logic [4:0] K_MODE_EXEC = 5'd17;
  localparam logic [4:0] K_TSC       = 5'd18;
  localparam logic [4:0] K_MTC       = 5'd19;
  localparam logic [4:0] K_CYC       = 5'd20;
  localparam logic [4:0] K_UNKNOWN   = 5'd21;
  localparam logic [4:0] K_SUMMARY   = 5'd22;

  localparam logic [7:0] H_EXT    = 8'h02;
  localparam logic [7:0] H_TNT64  = 8'ha3;
  localparam logic [7:0] H_PIP    = 8'h43;
  localparam logic [7:0] H_CBR    = 8'h03;
  localparam logic [7:0] H_STOP   = 8'h83;
  localparam logic [7:0] H_OVF    = 8'hf3;
  localparam logic [7:0] H_PSB    = 8'h82;
  localparam logic [7:0] H_PSBEND = 8'h23;
  localparam logic [7:0] H_MNT    = 8'hc3;
  localparam logic [7:0] H_MNT2   = 8'h88;
  localparam logic [7:0] H_TMA    = 8'h73;
  localparam logic [7:0] H_VMCS   = 8'hc8;
  localparam logic [7:0] H_MODE   = 8'h99;
  localparam logic [7:0] H_TSC    = 8'h19;
  localparam logic [7:0] H_MTC    = 8'h59;

  localparam logic [4:0] IP_TIP     = 5'h0d;
  localparam logic [4:0] IP_TIP_PGE = 5'h11;
  localparam logic [4:0] IP_TIP_PGD = 5'h01;
  localparam logic [4:0] IP_FUP     = 5'h1d;

endpackage
`default_nettype wire

// ===== hw/rtl/ptd_ctrl.sv =====
// Controller state machine of the trace packet decoder.
// Sequences accept, sync search, decode and summary; uses ptd_pkg.
`default_nettype none
module ptd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  input  wire ptd_pkg::ptd_status_t st,
  output ptd_pkg::ptd_cmd_t        cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_STEP = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (!st.in_sync && st.fill_full) begin
          cmd.sync_step = 1'b1;
        end else if (st.in_sync && (st.fill_full || (st.draining && st.fill_nz))) begin
          cmd.decode = 1'b1;
          state_nxt = S_OUT;
        end else if (st.draining) begin
          cmd.summary = 1'b1;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_STEP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

endmodule
`default_nettype wire

// ===== hw/rtl/ptd_datapath.sv =====
// Datapath of the trace packet decoder: byte window, counters, last IP,
// packet decode and the result register. Uses ptd_pkg.
`default_nettype none
module ptd_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ptd_pkg::in_item_t   in_item,
  input  wire ptd_pkg::ptd_cmd_t   cmd,
  output ptd_pkg::ptd_status_t     st,
  output ptd_pkg::out_item_t       out_item
);

  logic [7:0] w_r [ptd_pkg::WinBytes];
  logic [7:0] w_nxt [ptd_pkg::WinBytes];
  logic [7:0] mw [ptd_pkg::WinBytes];
  logic [ptd_pkg::FillW-1:0] fill_r, fill_nxt;
  logic sync_r, sync_nxt, drain_r, drain_nxt;
  logic [63:0] lastip_r, lastip_nxt;
  logic [ptd_pkg::CntW-1:0] skip_r, skip_nxt, ovf_r, ovf_nxt;
  logic [31:0] pos_r, pos_nxt;
  ptd_pkg::out_item_t out_r, out_nxt;

  logic psb_ok, full;
  logic [7:0] b0, b1;
  logic [47:0] le6;
  logic [4:0] d_kind;
  logic [63:0] d_pay;
  logic [31:0] d_aux;
  logic [5:0] d_cnt;
  logic d_err, d_ipwe, d_ovf, matched;
  logic [4:0] d_used;
  logic [1:0] tnt_sel;
  logic [63:0] ip_v;
  logic [2:0] ipl;
  logic [47:0] tnt_v;
  logic [5:0] tnt_j;
  logic [63:0] cyc;
  logic cyc_ext;
  logic cyc_err;
  logic [4:0] cyc_idx;
  logic [4:0] k;
  logic [5:0] sh;
  logic [ptd_pkg::CntW:0] sum_w;

  assign full = (fill_r == 5'(ptd_pkg::WinBytes));

  always_comb begin
    for (int i = 0; i < ptd_pkg::WinBytes; i++) begin
      mw[i] = (5'(i) < fill_r) ? w_r[i] : 8'd0;
    end
  end

  always_comb begin
    psb_ok = full;
    for (int i = 0; i < 16; i++) begin
      if (w_r[i] != (((i % 2) == 1) ? ptd_pkg::H_PSB : ptd_pkg::H_EXT)) begin
        psb_ok = 1'b0;
      end
    end
  end

  assign b0 = mw[0];
  assign b1 = mw[1];
  assign le6 = {mw[7], mw[6], mw[5], mw[4], mw[3], mw[2]};
  assign ipl = b0[7:5];

  always_comb begin
    cyc = {59'd0, b0[7:3]};
    cyc_ext = b0[2];
    cyc_idx = 5'd1;
    cyc_err = 1'b0;
    for (int i = 1; i < ptd_pkg::WinBytes; i++) begin
      if (cyc_ext && (5'(i) < fill_r)) begin
        if (5 + 7 * (i - 1) >= 64) begin
          if (mw[i][7:1] != 7'd0) cyc_err = 1'b1;
        end else begin
          cyc = cyc | (64'(mw[i][7:1]) << (5 + 7 * (i - 1)));
          if ((5 + 7 * (i - 1) > 57) && ((mw[i][7:1] >> (59 - 7 * (i - 1))) != 7'd0)) begin
            cyc_err = 1'b1;
          end
        end
        cyc_ext = mw[i][0];
        cyc_idx = 5'(i + 1);
      end
    end
    if (cyc_ext) cyc_err = 1'b1;
  end

  always_comb begin
    tnt_j = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (tnt_v[i]) tnt_j = 6'(i);
    end
  end

  always_comb begin
    d_kind = ptd_pkg::K_UNKNOWN;
    d_pay = {56'd0, b0};
    d_aux = 32'd0;
    d_cnt = 6'd0;
    d_err = 1'b0;
    d_used = 5'd0;
    d_ipwe = 1'b0;
    d_ovf = 1'b0;
    tnt_sel = 2'd0;
    matched = 1'b0;
    ip_v = lastip_r;
    tnt_v = le6;
    if (b0 == ptd_pkg::H_EXT && fill_r >= 5'd2) begin
      matched = 1'b1;
      d_pay = 64'd0;
      if (b1 == ptd_pkg::H_TNT64 && fill_r >= 5'd8) begin
        d_kind = ptd_pkg::K_TNT64; tnt_sel = 2'd2; d_used = 5'd8;
      end else if (b1 == ptd_pkg::H_PIP && fill_r >= 5'd8) begin
        d_kind = ptd_pkg::K_PIP; d_pay = {12'd0, le6[47:1], 5'd0}; d_used = 5'd8;
      end else if (b1 == ptd_pkg::H_CBR && fill_r >= 5'd4 && mw[3] == 8'd0) begin
        d_kind = ptd_pkg::K_CBR; d_pay = {56'd0, mw[2]}; d_used = 5'd4;
      end else if (b1 == ptd_pkg::H_STOP) begin
        d_kind = ptd_pkg::K_STOP; d_used = 5'd2;
      end else if (b1 == ptd_pkg::H_OVF) begin
        d_kind = ptd_pkg::K_OVF; d_used = 5'd2; d_ovf = 1'b1;
      end else if (b1 == ptd_pkg::H_PSB && psb_ok) begin
        d_kind = ptd_pkg::K_PSB; d_used = 5'd16;
      end else if (b1 == ptd_pkg::H_PSBEND) begin
        d_kind = ptd_pkg::K_PSBEND; d_used = 5'd2;
      end else if (b1 == ptd_pkg::H_MNT && fill_r >= 5'd11 && mw[2] == ptd_pkg::H_MNT2) begin
        d_kind = ptd_pkg::K_MNT;
        d_pay = {mw[10], mw[9], mw[8], mw[7], mw[6], mw[5], mw[4], mw[3]};
        d_used = 5'd11;
      end else if (b1 == ptd_pkg::H_TMA && fill_r >= 5'd7) begin
        d_kind = ptd_pkg::K_TMA; d_pay = {48'd0, mw[3], mw[2]};
        d_aux = {23'd0, mw[6][0], mw[5]}; d_used = 5'd7;
      end else if (b1 == ptd_pkg::H_VMCS && fill_r >= 5'd7) begin
        d_kind = ptd_pkg::K_VMCS;
        d_pay = {12'd0, mw[6], mw[5], mw[4], mw[3], mw[2], 12'd0};
        d_used = 5'd7;
      end else begin
        matched = 1'b0;
        d_pay = {56'd0, b0};
      end
    end
    if (!matched) begin
      if (!b0[0]) begin
        d_pay = 64'd0; d_used = 5'd1;
        if (b0 == 8'd0) begin
          d_kind = ptd_pkg::K_PAD;
        end else begin
          d_kind = ptd_pkg::K_TNT8; tnt_sel = 2'd1; tnt_v = {41'd0, b0[7:1]};
        end
      end else if (b0[4:0] == ptd_pkg::IP_TIP || b0[4:0] == ptd_pkg::IP_TIP_PGE ||
                   b0[4:0] == ptd_pkg::IP_TIP_PGD || b0[4:0] == ptd_pkg::IP_FUP) begin
        case (b0[4:0])
          ptd_pkg::IP_TIP:     d_kind = ptd_pkg::K_TIP;
          ptd_pkg::IP_TIP_PGE: d_kind = ptd_pkg::K_TIP_PGE;
          ptd_pkg::IP_TIP_PGD: d_kind = ptd_pkg::K_TIP_PGD;
          default:             d_kind = ptd_pkg::K_FUP;
        endcase
        d_aux = {29'd0, ipl};
        d_pay = 64'd0;
        d_used = 5'd1;
        if (ipl == 3'd0) begin
          d_ipwe = 1'b1; ip_v = 64'd0;
        end else if (ipl >= 3'd4) begin
          d_ipwe = 1'b0;
        end else if (fill_r < 5'd1 + {1'b0, ipl, 1'b0}) begin
          d_ipwe = 1'b1; ip_v = 64'd0; d_err = 1'b1;
        end else begin
          ip_v[15:0] = {mw[2], mw[1]};
          if (ipl >= 3'd2) ip_v[31:16] = {mw[4], mw[3]};
          if (ipl == 3'd3) ip_v[47:32] = {mw[6], mw[5]};
          ip_v[63:48] = {16{ip_v[47]}};
          d_ipwe = 1'b1; d_pay = ip_v;
          d_used = 5'd1 + {1'b0, ipl, 1'b0};
        end
      end else if (b0 == ptd_pkg::H_MODE && fill_r >= 5'd2 && b1[7:6] == 2'd0) begin
        d_kind = b1[5] ? ptd_pkg::K_MODE_TSX : ptd_pkg::K_MODE_EXEC;
        d_pay = {62'd0, b1[1:0]}; d_used = 5'd2;
      end else if (b0 == ptd_pkg::H_TSC && fill_r >= 5'd8) begin
        d_kind = ptd_pkg::K_TSC;
        d_pay = {8'd0, mw[7], mw[6], mw[5], mw[4], mw[3], mw[2], mw[1]};
        d_used = 5'd8;
      end else if (b0 == ptd_pkg::H_MTC && fill_r >= 5'd2) begin
        d_kind = ptd_pkg::K_MTC; d_pay = {56'd0, b1}; d_used = 5'd2;
      end else if (b0[1:0] == 2'b11) begin
        d_kind = ptd_pkg::K_CYC; d_pay = cyc; d_used = cyc_idx; d_err = cyc_err;
      end
    end
    if (tnt_sel != 2'd0) begin
      if (tnt_v == 48'd0) begin
        d_err = 1'b1;
      end else begin
        d_cnt = tnt_j;
        d_pay = {16'd0, tnt_v ^ (48'd1 << tnt_j)};
      end
    end
  end

  assign sum_w = {1'b0, skip_r} + (ptd_pkg::CntW + 1)'(fill_r);

  always_comb begin
    for (int i = 0; i < ptd_pkg::WinBytes; i++) w_nxt[i] = w_r[i];
    fill_nxt = fill_r;
    sync_nxt = sync_r;
    drain_nxt = drain_r;
    lastip_nxt = lastip_r;
    skip_nxt = skip_r;
    ovf_nxt = ovf_r;
    pos_nxt = pos_r;
    out_nxt = out_r;
    k = 5'd0;
    sh = 6'd0;
    if (cmd.accept) begin
      if (!full) begin
        w_nxt[fill_r[3:0]] = in_item.data_byte;
        fill_nxt = fill_r + 5'd1;
      end
      if (in_item.last_byte) drain_nxt = 1'b1;
    end
    if (cmd.sync_step) begin
      if (psb_ok) begin
        sync_nxt = 1'b1;
      end else begin
        k = 5'd1;
        if (skip_r != '1) skip_nxt = skip_r + 1'b1;
      end
    end
    if (cmd.decode) begin
      out_nxt.kind = d_kind;
      out_nxt.byte_offset = pos_r;
      out_nxt.payload = d_pay;
      out_nxt.aux_value = d_aux;
      out_nxt.tnt_count = d_cnt;
      out_nxt.error_flag = d_err;
      out_nxt.last_result = 1'b0;
      if (d_ipwe) lastip_nxt = ip_v;
      if (d_ovf && ovf_r != '1) ovf_nxt = ovf_r + 1'b1;
      if (d_used == 5'd0) sync_nxt = 1'b0;
      k = d_used;
    end
    if (k != 5'd0) begin
      for (int i = 0; i < ptd_pkg::WinBytes; i++) begin
        sh = 6'(i) + {1'b0, k};
        if (sh < 6'(ptd_pkg::WinBytes)) w_nxt[i] = w_r[sh[3:0]];
      end
      fill_nxt = fill_r - k;
      pos_nxt = pos_r + 32'(k);
    end
    if (cmd.summary) begin
      out_nxt.kind = ptd_pkg::K_SUMMARY;
      out_nxt.byte_offset = pos_r;
      out_nxt.payload = 64'(sum_w[ptd_pkg::CntW] ? {ptd_pkg::CntW{1'b1}}
                                                : sum_w[ptd_pkg::CntW-1:0]);
      out_nxt.aux_value = 32'(ovf_r);
      out_nxt.tnt_count = 6'd0;
      out_nxt.error_flag = 1'b0;
      out_nxt.last_result = 1'b1;
      fill_nxt = '0;
      sync_nxt = 1'b0;
      drain_nxt = 1'b0;
      lastip_nxt = 64'd0;
      skip_nxt = '0;
      ovf_nxt = '0;
      pos_nxt = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      sync_r <= 1'b0;
      drain_r <= 1'b0;
      lastip_r <= 64'd0;
      skip_r <= '0;
      ovf_r <= '0;
      pos_r <= 32'd0;
    end else begin
      fill_r <= fill_nxt;
      sync_r <= sync_nxt;
      drain_r <= drain_nxt;
      lastip_r <= lastip_nxt;
      skip_r <= skip_nxt;
      ovf_r <= ovf_nxt;
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ptd_pkg::WinBytes; i++) w_r[i] <= w_nxt[i];
    out_r <= out_nxt;
  end

  assign st.in_sync = sync_r;
  assign st.fill_full = full;
  assign st.fill_nz = (fill_r != '0);
  assign st.draining = drain_r;
  assign out_item = out_r;

endmodule
`default_nettype wire

// ===== hw/rtl/pt_trace_packet_decoder.sv =====
// Processor-trace packet decoder top level; instantiates ptd_ctrl and
// ptd_datapath and uses ptd_pkg.
// An item is accepted and examined in the next cycle, so a byte that yields no result
// returns the controller to idle to let the next item in; each sync-search step stays
// in the step state and each result passes decode then output, plus any wait until taken.
// Synchronous active-low reset clears the window fill, sync, counters and state.
`default_nettype none
module pt_trace_packet_decoder (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ptd_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ptd_pkg::out_item_t      out_item
);

  ptd_pkg::ptd_cmd_t    cmd;
  ptd_pkg::ptd_status_t st;

  ptd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  ptd_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .st       (st),
    .out_item (out_item)
  );

  a_no_accept_while_result : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input accepted while a result waits");

  a_summary_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_item.last_result) |-> (!st.in_sync && !st.fill_nz))
    else $error("state not cleared after summary");

endmodule
`default_nettype wire

// ===== test/tb_pt_trace_packet_decoder.sv =====
// Self-checking testbench for the trace packet decoder top level.
// Holds a scoreboard class that predicts decoded packets, plus the drivers.
// Depends on ptd_pkg and pt_trace_packet_decoder.
`timescale 1ns / 100ps
`default_nettype none
module tb_pt_trace_packet_decoder;
  import ptd_pkg::*;

  localparam int StallLimit = 2000;
  localparam int HoldOff = 300;
  localparam longint unsigned SatMax = 64'hffff_ffff;

  class ptd_packet_scoreboard;
    logic [7:0] win [16];
    int unsigned fill;
    bit synced;
    bit draining;
    logic [63:0] last_ip;
    longint unsigned skipped;
    longint unsigned ovfs;
    logic [31:0] pos;
    out_item_t expected_packets[$];
    int errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      foreach (win[i]) win[i] = '0;
      fill = 0;
      synced = 0;
      draining = 0;
      last_ip = '0;
      skipped = 0;
      ovfs = 0;
      pos = '0;
    endfunction

    function longint unsigned sat(longint unsigned a, longint unsigned b);
      longint unsigned s;
      s = a + b;
      if (s < a || s > SatMax) return SatMax;
      return s;
    endfunction

    function logic [7:0] wb(int unsigned i);
      if (i < fill && i < 16) return win[i];
      return 8'h00;
    endfunction

    function logic [63:0] le(int unsigned from, int unsigned cnt);
      logic [63:0] v;
      v = '0;
      for (int unsigned i = 0; i < cnt && i < 8; i++) v |= 64'(wb(from + i)) << (8 * i);
      return v;
    endfunction

    function bit sync_head();
      if (fill < 16) return 0;
      for (int i = 0; i < 16; i++)
        if (win[i] != ((i & 1) ? H_PSB : H_EXT)) return 0;
      return 1;
    endfunction

    function void drop(int unsigned k);
      if (k > fill) k = fill;
      for (int unsigned i = 0; i + k < fill; i++) win[i] = win[i + k];
      fill -= k;
      pos += k;
    endfunction

    function void tnt_from(logic [63:0] v, inout out_item_t r);
      int j;
      if (v == 0) begin
        r.error_flag = 1;
        return;
      end
      j = 0;
      for (int i = 0; i < 64; i++) if (v[i]) j = i;
      r.tnt_count = 6'(j);
      r.payload = v & ((64'd1 << j) - 1);
    endfunction

    function int unsigned decode(output out_item_t r);
      int unsigned n, ipl, s, idx;
      logic [7:0] b0, b1, b;
      logic [63:0] v, cyc, bits;
      bit ext;
      r = '0;
      n = fill;
      b0 = wb(0);
      b1 = wb(1);
      r.byte_offset = pos;
      if (b0 == H_EXT && n >= 2) begin
        if (b1 == H_TNT64 && n >= 8) begin
          r.kind = K_TNT64;
          tnt_from(le(2, 6), r);
          return 8;
        end
        if (b1 == H_PIP && n >= 8) begin
          r.kind = K_PIP;
          r.payload = (le(2, 6) >> 1) << 5;
          return 8;
        end
        if (b1 == H_CBR && n >= 4 && wb(3) == 0) begin
          r.kind = K_CBR;
          r.payload = 64'(wb(2));
          return 4;
        end
        if (b1 == H_STOP) begin
          r.kind = K_STOP;
          return 2;
        end
        if (b1 == H_OVF) begin
          r.kind = K_OVF;
          ovfs = sat(ovfs, 1);
          return 2;
        end
        if (b1 == H_PSB && sync_head()) begin
          r.kind = K_PSB;
          return 16;
        end
        if (b1 == H_PSBEND) begin
          r.kind = K_PSBEND;
          return 2;
        end
        if (b1 == H_MNT && n >= 11 && wb(2) == H_MNT2) begin
          r.kind = K_MNT;
          r.payload = le(3, 8);
          return 11;
        end
        if (b1 == H_TMA && n >= 7) begin
          r.kind = K_TMA;
          r.payload = le(2, 2);
          b = wb(6);
          r.aux_value = {23'd0, b[0], wb(5)};
          return 7;
        end
        if (b1 == H_VMCS && n >= 7) begin
          r.kind = K_VMCS;
          r.payload = le(2, 5) << 12;
          return 7;
        end
      end
      if (b0[0] == 0) begin
        if (b0 == 0) begin
          r.kind = K_PAD;
          return 1;
        end
        r.kind = K_TNT8;
        tnt_from(64'(b0 >> 1), r);
        return 1;
      end
      case (b0[4:0])
        IP_TIP: r.kind = K_TIP;
        IP_TIP_PGE: r.kind = K_TIP_PGE;
        IP_TIP_PGD: r.kind = K_TIP_PGD;
        IP_FUP: r.kind = K_FUP;
        default: r.kind = K_PAD;
      endcase
      if (r.kind != K_PAD) begin
        ipl = b0[7:5];
        r.aux_value = ipl;
        if (ipl == 0) begin
          last_ip = '0;
          return 1;
        end
        if (ipl >= 4) return 1;
        if (n < 1 + 2 * ipl) begin
          last_ip = '0;
          r.error_flag = 1;
          return 1;
        end
        v = last_ip;
        for (int unsigned i = 0; i < ipl; i++) begin
          s = 16 * i;
          v = (v & ~(64'hffff << s)) | (le(1 + 2 * i, 2) << s);
        end
        v[63:48] = v[47] ? 16'hffff : 16'h0000;
        last_ip = v;
        r.payload = v;
        return 1 + 2 * ipl;
      end
      if (b0 == H_MODE && n >= 2) begin
        if (b1[7:5] == 1) begin
          r.kind = K_MODE_TSX;
          r.payload = 64'(b1[1:0]);
          return 2;
        end
        if (b1[7:5] == 0) begin
          r.kind = K_MODE_EXEC;
          r.payload = 64'(b1[1:0]);
          return 2;
        end
      end
      if (b0 == H_TSC && n >= 8) begin
        r.kind = K_TSC;
        r.payload = le(1, 7);
        return 8;
      end
      if (b0 == H_MTC && n >= 2) begin
        r.kind = K_MTC;
        r.payload = 64'(b1);
        return 2;
      end
      if (b0[1:0] == 2'b11) begin
        cyc = 64'(b0 >> 3);
        s = 5;
        idx = 1;
        ext = b0[2];
        r.kind = K_CYC;
        while (ext && idx < n) begin
          b = wb(idx);
          bits = 64'(b >> 1);
          if (s >= 64) begin
            if (bits != 0) r.error_flag = 1;
          end else begin
            cyc |= bits << s;
            if (s > 57 && (bits >> (64 - s)) != 0) r.error_flag = 1;
          end
          ext = b[0];
          idx++;
          s += 7;
        end
        if (ext) r.error_flag = 1;
        r.payload = cyc;
        return idx;
      end
      r.kind = K_UNKNOWN;
      r.payload = 64'(b0);
      return 0;
    endfunction

    function void note_trace_byte(in_item_t it);
      out_item_t r;
      int unsigned used;
      if (fill < 16) begin
        win[fill] = it.data_byte;
        fill++;
      end
      if (it.last_byte) draining = 1;
      while (1) begin
        while (!synced && fill >= 16) begin
          if (sync_head()) begin
            synced = 1;
          end else begin
            drop(1);
            skipped = sat(skipped, 1);
          end
        end
        if (!synced) break;
        if (!(fill == 16 || (draining && fill > 0))) break;
        used = decode(r);
        expected_packets.push_back(r);
        if (used == 0) synced = 0;
        else drop(used);
      end
      if (draining) begin
        r = '0;
        r.kind = K_SUMMARY;
        r.byte_offset = pos;
        r.payload = sat(skipped, fill);
        r.aux_value = ovfs[31:0];
        r.last_result = 1;
        expected_packets.push_back(r);
        clear();
      end
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    task check_packet(out_item_t got);
      out_item_t want;
      if (expected_packets.size() == 0) begin
        report("unexpected packet kind", 64'(got.kind), '0);
        return;
      end
      want = expected_packets.pop_front();
      if (got.kind != want.kind) report("kind", 64'(got.kind), 64'(want.kind));
      if (got.byte_offset != want.byte_offset)
        report("byte_offset", 64'(got.byte_offset), 64'(want.byte_offset));
      if (got.payload != want.payload) report("payload", got.payload, want.payload);
      if (got.aux_value != want.aux_value)
        report("aux_value", 64'(got.aux_value), 64'(want.aux_value));
      if (got.tnt_count != want.tnt_count)
        report("tnt_count", 64'(got.tnt_count), 64'(want.tnt_count));
      if (got.error_flag != want.error_flag)
        report("error_flag", 64'(got.error_flag), 64'(want.error_flag));
      if (got.last_result != want.last_result)
        report("last_result", 64'(got.last_result), 64'(want.last_result));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;

  ptd_packet_scoreboard sb = new();
  logic [7:0] trace_bytes[$];
  in_item_t stim[$];
  int results_seen;
  int idle_cycles;

  pt_trace_packet_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic void push_rand(int n);
    for (int i = 0; i < n; i++) trace_bytes.push_back(8'($urandom));
  endfunction

  function automatic void push_psb();
    for (int i = 0; i < 8; i++) begin
      trace_bytes.push_back(H_EXT);
      trace_bytes.push_back(H_PSB);
    end
  endfunction

  function automatic void push_packet(int sel);
    int ipl;
    logic [4:0] code;
    case (sel)
      0: trace_bytes.push_back(8'h00);
      1: trace_bytes.push_back({7'($urandom), 1'b0});
      2: begin
        trace_bytes.push_back(H_EXT);
        trace_bytes.push_back(H_TNT64);
        if ($urandom_range(0, 9) == 0) for (int i = 0; i < 6; i++) trace_bytes.push_back(8'h00);
        else push_rand(6);
      end
      3: begin
        trace_bytes.push_back(H_EXT);
        trace_bytes.push_back(H_PIP);
        push_rand(6);
      end
      4: begin
        trace_bytes.push_back(H_EXT);
        trace_bytes.push_back(H_CBR);
        push_rand(1);
        trace_bytes.push_back($urandom_range(0, 4) == 0 ? 8'($urandom) : 8'h00);
      end
      5: begin
        trace_bytes.push_back(H_EXT);
        trace_bytes.push_back(H_STOP);
      end
      6: begin
        trace_bytes.push_back(H_EXT);
        trace_bytes.push_back(H_OVF);
      end
      7: push_psb();
      8: begin
        trace_bytes.push_back(H_EXT);
        trace_bytes.push_back(H_PSBEND);
      end
      9: begin
        trace_bytes.push_back(H_EXT);
        trace_bytes.push_back(H_MNT);
        trace_bytes.push_back(H_MNT2);
        push_rand(8);
      end
      10: begin
        trace_bytes.push_back(H_EXT);
        trace_bytes.push_back(H_TMA);
        push_rand(5);
      end
      11: begin
        trace_bytes.push_back(H_EXT);
        trace_bytes.push_back(H_VMCS);
        push_rand(5);
      end
      12: begin
        case ($urandom_range(0, 3))
          0: code = IP_TIP;
          1: code = IP_TIP_PGE;
          2: code = IP_TIP_PGD;
          default: code = IP_FUP;
        endcase
        ipl = $urandom_range(0, 7);
        trace_bytes.push_back({3'(ipl), code});
        push_rand(ipl < 4 ? 2 * ipl : $urandom_range(0, 6));
      end
      13: begin
        trace_bytes.push_back(H_MODE);
        trace_bytes.push_back({3'($urandom_range(0, 2)), 5'($urandom)});
      end
      14: begin
        trace_bytes.push_back(H_TSC);
        push_rand(7);
      end
      15: begin
        trace_bytes.push_back(H_MTC);
        push_rand(1);
      end
      16: begin
        ipl = $urandom_range(0, 10);
        trace_bytes.push_back({5'($urandom), 1'(ipl > 0), 2'b11});
        for (int i = 1; i < ipl; i++) trace_bytes.push_back({7'($urandom), 1'b1});
        if (ipl > 0 && $urandom_range(0, 7) != 0) trace_bytes.push_back({7'($urandom), 1'b0});
      end
      default: push_rand(1);
    endcase
  endfunction

  function automatic void close_buffer(int chop);
    while (chop > 0 && trace_bytes.size() > 1) begin
      void'(trace_bytes.pop_back());
      chop--;
    end
    foreach (trace_bytes[i]) stim.push_back({trace_bytes[i], 1'b0});
    stim[stim.size() - 1].last_byte = 1'b1;
    trace_bytes.delete();
  endfunction

  task automatic send_all();
    int gap;
    bit busy;
    busy = 0;
    foreach (stim[i]) begin
      if ($urandom_range(0, 39) == 0) busy = !busy;
      gap = busy ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_item <= stim[i];
      do @(posedge clk); while (in_stall);
      sb.note_trace_byte(stim[i]);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    int gap;
    bit busy;
    bit held;
    busy = 0;
    held = 0;
    results_seen = 0;
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) busy = !busy;
      gap = busy ? 0 : $urandom_range(0, 16);
      if (!held && results_seen == 40) begin
        held = 1;
        gap = HoldOff;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_packet(out_item);
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int nbytes;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    idle_cycles = 0;

    // Short checks: no sync with tail bytes, a lone final byte, then a synced buffer.
    trace_bytes.push_back(8'h00);
    trace_bytes.push_back(8'hff);
    close_buffer(0);
    trace_bytes.push_back(8'h80);
    close_buffer(0);
    push_psb();
    push_packet(6);
    trace_bytes.push_back({3'd3, IP_TIP});
    push_rand(6);
    trace_bytes.push_back(8'h05);
    close_buffer(0);

    nbytes = stim.size();
    while (stim.size() - nbytes < 470) begin
      if ($urandom_range(0, 6) == 0) begin
        push_rand($urandom_range(1, 30));
        close_buffer(0);
      end else begin
        push_rand($urandom_range(0, 5));
        push_psb();
        repeat ($urandom_range(3, 15)) push_packet($urandom_range(0, 17));
        close_buffer($urandom_range(0, 4) == 0 ? $urandom_range(1, 6) : 0);
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    send_all();
    while (sb.expected_packets.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
